// ----- hw/rtl/twg_pkg.sv -----
// ----------------------------------------------------------------------------
// twg_pkg: shared types and constants for the wave grid step block
// Grid geometry, command codes and the payload structs of each channel.
// ----------------------------------------------------------------------------
package twg_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;
   localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
   localparam int IDX_W       = $clog2(CELLS);
   localparam int PORTS       = 4;

   localparam logic [1:0] CMD_INJECT = 2'd0;
   localparam logic [1:0] CMD_STEP   = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [15:0] FRICTION_RESET = 16'd32768;

   typedef struct packed {
      logic [1:0]         command;
      logic [5:0]         cell_x;
      logic [5:0]         cell_y;
      logic signed [15:0] velocity_x;
      logic signed [15:0] velocity_y;
   } twg_req_type;

   typedef struct packed {
      logic signed [31:0] cell_height;
      logic [1:0]         done_command;
   } twg_rsp_type;

   // classified job handed from the front to the back
   typedef struct packed {
      logic [1:0]       command;
      logic [IDX_W-1:0] cell_idx;
      logic [31:0]      energy;
   } twg_job_type;

endpackage

// ----- hw/rtl/tlm_wave_grid_step_top.sv -----
// ----------------------------------------------------------------------------
// tlm_wave_grid_step_top: 2-D transmission-line-matrix wave grid
// Front intake, job queue and grid engine with the pulse memories.
// ----------------------------------------------------------------------------
// Throughput: the engine serves one job at a time and takes the next only
//   once the last response beat has been taken; a step occupies it for two
//   full grid sweeps plus drain, one cell a cycle.
// Reset: synchronous; afterwards a clearing sweep zeros all memories
//   before the first job runs (requests still queue, csr writes are taken).
// ----------------------------------------------------------------------------
module tlm_wave_grid_step_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [15:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  twg_pkg::twg_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output twg_pkg::twg_rsp_type rsp_data
);
   import twg_pkg::*;

   // front -> queue
   logic        f_valid, f_ready;
   twg_job_type f_job;
   // queue -> engine
   logic        q_valid, q_ready;
   twg_job_type q_job;

   // intake: squares velocities, forms inject energy
   twg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job_data  (f_job)
   );

   // decouples intake from a long step
   twg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_job),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_job)
   );

   // engine: memories, sweeps, response beat
   twg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job_data  (q_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/twg_front.sv -----
// ----------------------------------------------------------------------------
// twg_front: request intake
// Takes request beats, squares the velocities and forms the inject energy.
// ----------------------------------------------------------------------------
module twg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  twg_pkg::twg_req_type req_data,
   output logic                 job_valid,
   input  logic                 job_ready,
   output twg_pkg::twg_job_type job_data
);
   import twg_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_cmd_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [30:0]          sqx_ff, sqy_ff;
   logic signed [31:0]   sqx_full, sqy_full;
   logic [31:0]          sq_sum;
   logic [36:0]          energy_wide;
   logic                 take;

   assign req_ready = !s1_valid_ff || job_ready;
   assign take      = req_valid && req_ready;

   assign sqx_full = req_data.velocity_x * req_data.velocity_x;
   assign sqy_full = req_data.velocity_y * req_data.velocity_y;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (job_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff <= req_data.command;
         s1_idx_ff <= {req_data.cell_y, req_data.cell_x};
         sqx_ff    <= sqx_full[30:0];
         sqy_ff    <= sqy_full[30:0];
      end
   end

   // 20*e as (e<<4)+(e<<2), then clamp to the positive range
   assign sq_sum      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign energy_wide = {1'b0, sq_sum, 4'b0} + {3'b0, sq_sum, 2'b0};

   assign job_valid         = s1_valid_ff;
   assign job_data.command  = s1_cmd_ff;
   assign job_data.cell_idx = s1_idx_ff;
   assign job_data.energy   = (energy_wide > 37'h07FFFFFFF) ? 32'h7FFFFFFF
                                                            : energy_wide[31:0];

endmodule

// ----- hw/rtl/twg_queue.sv -----
// ----------------------------------------------------------------------------
// twg_queue: job queue
// Four-entry queue between intake and execution.
// ----------------------------------------------------------------------------
module twg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  twg_pkg::twg_job_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output twg_pkg::twg_job_type out_data
);
   import twg_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   twg_job_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff;
   logic               push, pop;

   assign in_ready  = (count_ff != (PTR_W+1)'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

endmodule

// ----- hw/rtl/twg_back.sv -----
// ----------------------------------------------------------------------------
// twg_back: grid engine
// Holds the pulse and height memories, runs the scatter and connect sweeps,
// serves inject and read, and drives the response register.
// ----------------------------------------------------------------------------
module twg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [15:0]          csr_wdata,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  twg_pkg::twg_job_type job_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output twg_pkg::twg_rsp_type rsp_data
);
   import twg_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SCAT  = 5'b01000,
      ST_CONN  = 5'b10000
   } twg_state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(GRID_WIDTH);

   function automatic logic interior(input logic [IDX_W-1:0] a);
      logic [5:0] x, y;
      x = a[5:0];
      y = a[IDX_W-1:6];
      return (x != 6'd0) && (x != 6'(GRID_WIDTH - 1)) &&
             (y != 6'd0) && (y != 6'(GRID_HEIGHT - 1));
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh007FFFFFFF)       return 32'sh7FFFFFFF;
      else if (v < -36'sh0080000000) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   // memories: an incoming and an outgoing one per pulse port, plus heights
   logic signed [31:0] in_mem     [PORTS][CELLS];
   logic signed [31:0] out_mem    [PORTS][CELLS];
   logic signed [31:0] height_mem [CELLS];

   twg_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               issue_ff, issue_in;
   logic               v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]   a1_ff, a2_ff, a3_ff;
   logic [15:0]        fric_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   twg_rsp_type        rsp_data_ff, rsp_data_in;
   logic               rsp_load;

   logic signed [31:0] in_rd_ff  [PORTS];
   logic signed [31:0] out_rd_ff [PORTS];
   logic signed [31:0] height_rd_ff;
   logic signed [34:0] d_ff      [PORTS];
   logic signed [51:0] prod_ff   [PORTS];
   logic signed [31:0] cin_ff    [PORTS];
   logic signed [32:0] s01_ff, s23_ff;
   logic signed [33:0] sum4;
   logic [IDX_W-1:0]   out_ra    [PORTS];

   logic               in_we [PORTS];
   logic [IDX_W-1:0]   in_wa;
   logic signed [31:0] in_wd [PORTS];
   logic               out_we;
   logic [IDX_W-1:0]   out_wa;
   logic signed [31:0] out_wd [PORTS];
   logic               height_we;
   logic [IDX_W-1:0]   height_wa;
   logic signed [31:0] height_wd;

   logic               start, pipe_empty, scat_wr, conn_wr;

   assign start      = (state_ff == ST_IDLE) && job_valid && !rsp_valid_ff;
   assign job_ready  = start;
   assign pipe_empty = !issue_ff && !v1_ff && !v2_ff && !v3_ff;
   assign scat_wr    = (state_ff == ST_SCAT) && v3_ff && interior(a3_ff);
   assign conn_wr    = (state_ff == ST_CONN) && v2_ff && interior(a2_ff);

   // neighbor taps for connect: in0<-out2 below, in1<-out3 right,
   // in2<-out0 above, in3<-out1 left
   assign out_ra[0] = cnt_ff - ROW_STEP;
   assign out_ra[1] = cnt_ff - 1'b1;
   assign out_ra[2] = cnt_ff + ROW_STEP;
   assign out_ra[3] = cnt_ff + 1'b1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      issue_in = issue_ff;
      rsp_load = 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               rsp_data_in.cell_height  = '0;
               rsp_data_in.done_command = job_data.command;
               if (job_data.command == CMD_STEP) begin
                  state_in = ST_SCAT;
                  cnt_in   = '0;
                  issue_in = 1'b1;
               end else if (job_data.command == CMD_READ) begin
                  state_in = ST_READ;
               end else begin
                  rsp_load = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_load = 1'b1;
            rsp_data_in.cell_height = height_rd_ff;
            state_in = ST_IDLE;
         end
         ST_SCAT, ST_CONN: begin
            if (issue_ff) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) issue_in = 1'b0;
            end else if (pipe_empty) begin
               if (state_ff == ST_SCAT) begin
                  state_in = ST_CONN;
                  cnt_in   = '0;
                  issue_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
                  rsp_load = 1'b1;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         fric_ff      <= FRICTION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ff     <= issue_in;
         v1_ff        <= issue_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) fric_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      a1_ff <= cnt_ff;
      a2_ff <= a1_ff;
      a3_ff <= a2_ff;
   end

   // scatter datapath: sum, subtract, multiply, floor and clamp
   assign sum4 = 34'(in_rd_ff[0]) + 34'(in_rd_ff[1]) + 34'(in_rd_ff[2]) + 34'(in_rd_ff[3]);

   always_ff @(posedge clock) begin
      for (int k = 0; k < PORTS; k++) begin
         d_ff[k]    <= 35'(sum4) - (35'(in_rd_ff[k]) <<< 1);
         prod_ff[k] <= d_ff[k] * $signed({1'b0, fric_ff});
      end
   end

   // connect datapath
   always_ff @(posedge clock) begin
      cin_ff[0] <= out_rd_ff[2];
      cin_ff[1] <= out_rd_ff[3];
      cin_ff[2] <= out_rd_ff[0];
      cin_ff[3] <= out_rd_ff[1];
      s01_ff    <= 33'(out_rd_ff[2]) + 33'(out_rd_ff[3]);
      s23_ff    <= 33'(out_rd_ff[0]) + 33'(out_rd_ff[1]);
   end

   // memory write selection
   always_comb begin
      in_wa     = cnt_ff;
      out_we    = 1'b0;
      out_wa    = cnt_ff;
      height_we = 1'b0;
      height_wa = cnt_ff;
      height_wd = '0;
      for (int k = 0; k < PORTS; k++) begin
         in_we[k]  = 1'b0;
         in_wd[k]  = '0;
         out_wd[k] = '0;
      end
      if (state_ff == ST_CLEAR) begin
         out_we    = 1'b1;
         height_we = 1'b1;
         for (int k = 0; k < PORTS; k++) in_we[k] = 1'b1;
      end else if (conn_wr) begin
         in_wa     = a2_ff;
         height_we = 1'b1;
         height_wa = a2_ff;
         height_wd = sat32(36'(s01_ff) + 36'(s23_ff));
         for (int k = 0; k < PORTS; k++) begin
            in_we[k] = 1'b1;
            in_wd[k] = cin_ff[k];
         end
      end else if (start && (job_data.command == CMD_INJECT)) begin
         in_we[0] = 1'b1;
         in_wa    = job_data.cell_idx;
         in_wd[0] = job_data.energy;
      end
      if (scat_wr) begin
         out_we = 1'b1;
         out_wa = a3_ff;
         for (int k = 0; k < PORTS; k++) out_wd[k] = sat32(prod_ff[k][51:16]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PORTS; k++) begin
         if (in_we[k]) in_mem[k][in_wa] <= in_wd[k];
         in_rd_ff[k] <= in_mem[k][cnt_ff];
         if (out_we) out_mem[k][out_wa] <= out_wd[k];
         out_rd_ff[k] <= out_mem[k][out_ra[k]];
      end
      if (height_we) height_mem[height_wa] <= height_wd;
      height_rd_ff <= height_mem[job_data.cell_idx];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_ready |-> (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("job taken outside idle");
   a_no_out_in_conn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONN) |-> !out_we)
      else $error("outgoing pulses written during connect");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff)
      else $error("response overwritten");
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(start) && ($past(job_data.command) == CMD_READ))
      else $error("read state without read job");

endmodule

// ----- test/twg_checker.sv -----
// ----------------------------------------------------------------------------
// twg_checker: response checker for the wave grid step block
// Watches the request, response and csr ports, keeps a shadow copy of the
// grid and compares every response beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module twg_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [15:0]          csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  twg_pkg::twg_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  twg_pkg::twg_rsp_type rsp_data,
   output int                   errors,
   output int                   pending
);
   import twg_pkg::*;

   int          pulse_in  [CELLS*PORTS];
   int          pulse_out [CELLS*PORTS];
   int          height    [CELLS];
   logic [15:0] friction = FRICTION_RESET;
   twg_rsp_type rsp_queue [$];

   initial errors = 0;
   assign pending = rsp_queue.size();

   function automatic int clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   // floor(sum * friction / 2^16), arithmetic shift floors negatives too
   function automatic int damped(longint sum);
      longint prod;
      prod = sum * longint'({48'd0, friction});
      return clip32(prod >>> 16);
   endfunction

   function automatic void grid_step();
      int     c;
      longint total;
      for (int y = 1; y < GRID_HEIGHT-1; y++)
         for (int x = 1; x < GRID_WIDTH-1; x++) begin
            c     = y*GRID_WIDTH + x;
            total = 0;
            for (int k = 0; k < PORTS; k++) total += pulse_in[c*4+k];
            for (int k = 0; k < PORTS; k++)
               pulse_out[c*4+k] = damped(total - 2*longint'(pulse_in[c*4+k]));
         end
      for (int y = 1; y < GRID_HEIGHT-1; y++)
         for (int x = 1; x < GRID_WIDTH-1; x++) begin
            c = y*GRID_WIDTH + x;
            pulse_in[c*4+0] = pulse_out[(c+GRID_WIDTH)*4+2];
            pulse_in[c*4+1] = pulse_out[(c+1)*4+3];
            pulse_in[c*4+2] = pulse_out[(c-GRID_WIDTH)*4+0];
            pulse_in[c*4+3] = pulse_out[(c-1)*4+1];
            total = 0;
            for (int k = 0; k < PORTS; k++) total += pulse_in[c*4+k];
            height[c] = clip32(total);
         end
   endfunction

   function automatic twg_rsp_type predict(twg_req_type r);
      twg_rsp_type res;
      int          c;
      longint      vx, vy, e;
      c   = int'(r.cell_y)*GRID_WIDTH + int'(r.cell_x);
      res = '0;
      res.done_command = r.command;
      case (r.command)
         CMD_INJECT: begin
            vx = r.velocity_x;
            vy = r.velocity_y;
            e  = (vx*vx + vy*vy) * 20;
            pulse_in[c*4] = (e > 64'sd2147483647) ? 32'h7FFF_FFFF : int'(e);
         end
         CMD_STEP: grid_step();
         CMD_READ: res.cell_height = height[c];
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      twg_rsp_type want;
      if (!reset) begin
         if (csr_we) friction <= csr_wdata;
         if (req_valid && req_ready) rsp_queue.push_back(predict(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, actual h=%0d cmd=%0d", $time,
                        rsp_data.cell_height, rsp_data.done_command);
            end else begin
               want = rsp_queue.pop_front();
               if (want.cell_height !== rsp_data.cell_height) begin
                  errors++;
                  $display("%0t: cell_height expected %0d actual %0d", $time,
                           want.cell_height, rsp_data.cell_height);
               end
               if (want.done_command !== rsp_data.done_command) begin
                  errors++;
                  $display("%0t: done_command expected %0d actual %0d", $time,
                           want.done_command, rsp_data.done_command);
               end
            end
         end
      end
   end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the wave grid step block
// Directed inject/step/read sequences, then random traffic over four
// friction settings with different sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import twg_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   twg_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   twg_rsp_type rsp_data;
   int          errors, pending;
   int          cycles = 0;
   int          send_idle_pct = 0;   // chance of a gap after a request beat
   int          rsp_stall_pct = 0;   // chance of holding rsp_ready low

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tlm_wave_grid_step_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   twg_checker chk (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .errors(errors), .pending(pending)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic twg_req_type item(logic [1:0] cmd, int x, int y,
                                        int vx, int vy);
      twg_req_type r;
      r.command    = cmd;
      r.cell_x     = x[5:0];
      r.cell_y     = y[5:0];
      r.velocity_x = vx[15:0];
      r.velocity_y = vy[15:0];
      return r;
   endfunction

   // One beat; valid stays up into the next beat unless a gap is drawn.
   task automatic send(twg_req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // csr writes only happen with nothing in flight; the task first waits so the
   // checker has queued the last accepted beat
   task automatic write_friction(logic [15:0] f);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= f;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly a cluster near the grid center so pulses meet and reads see them;
   // the rest spans the full coordinate range, boundaries included.
   function automatic twg_req_type random_item();
      int          pick, x, y, vx, vy;
      logic [1:0]  cmd;
      pick = $urandom_range(99);
      if (pick < 8)       cmd = CMD_STEP;
      else if (pick < 12) cmd = CMD_NONE;
      else if (pick < 50) cmd = CMD_INJECT;
      else                cmd = CMD_READ;
      if ($urandom_range(99) < 70) begin
         x = $urandom_range(26, 37);
         y = $urandom_range(26, 37);
      end else begin
         x = $urandom_range(63);
         y = $urandom_range(63);
      end
      if ($urandom_range(3) == 0) begin
         vx = $urandom;
         vy = $urandom;
      end else begin
         vx = $urandom_range(2047) * ($urandom_range(1) ? 1 : -1);
         vy = $urandom_range(2047) * ($urandom_range(1) ? 1 : -1);
      end
      return item(cmd, x, y, vx, vy);
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, boundary, out-of-use code, wave spreading
      send(item(CMD_INJECT, 32, 32, -32768, -32768));   // saturates
      send(item(CMD_INJECT, 33, 32, 32767, 0));
      send(item(CMD_INJECT, 31, 32, 0, 0));
      send(item(CMD_INJECT, 20, 20, 255, -256));
      send(item(CMD_INJECT, 0, 0, 100, 100));           // boundary cell
      send(item(CMD_INJECT, 63, 63, 1, 1));
      send(item(CMD_NONE, 63, 0, 32767, -1));
      send(item(CMD_READ, 32, 32, 0, 0));
      send(item(CMD_STEP, 0, 0, 0, 0));
      send(item(CMD_READ, 32, 31, 0, 0));
      send(item(CMD_READ, 32, 33, 0, 0));
      send(item(CMD_READ, 21, 20, 0, 0));
      send(item(CMD_READ, 0, 0, 0, 0));
      send(item(CMD_READ, 63, 63, 0, 0));
      send(item(CMD_STEP, 0, 0, 0, 0));
      send(item(CMD_READ, 32, 32, 0, 0));
      send(item(CMD_READ, 34, 32, 0, 0));
      send(item(CMD_READ, 31, 33, 0, 0));

      // phases: friction setting together with the idle pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_friction(16'd32768); send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin write_friction(16'hFFFF);  send_idle_pct = 61; rsp_stall_pct = 0;  end
            2: begin write_friction(16'd0);     send_idle_pct = 0;  rsp_stall_pct = 61; end
            default: begin
               write_friction(16'($urandom_range(32768)));
               send_idle_pct = 17; rsp_stall_pct = 17;
            end
         endcase
         for (int n = 0; n < 25; n++) send(random_item());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/twg_pkg.sv
hw/rtl/twg_front.sv
hw/rtl/twg_queue.sv
hw/rtl/twg_back.sv
hw/rtl/tlm_wave_grid_step_top.sv
test/twg_checker.sv
test/tb_top.sv
